// File: sv/round_robin_task_scheduler_unit_macros.svh
// Assertion helpers for the scheduler top level
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RRTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rrts_pkg.sv
package rrts_pkg;

  // Table geometry
  localparam int MAX_TASKS = 8;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int OP_W      = 3;
  localparam int RES_W     = 2;

  // Slot states
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_ZOMBIE  = 2'd3;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_FORK  = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
  localparam logic [OP_W-1:0] OP_YIELD = 3'd2;
  localparam logic [OP_W-1:0] OP_EXIT  = 3'd3;
  localparam logic [OP_W-1:0] OP_JOIN  = 3'd4;
  localparam logic [OP_W-1:0] OP_PEN   = 3'd5;
  localparam logic [OP_W-1:0] OP_PDIS  = 3'd6;

  // Result status codes
  localparam logic [RES_W-1:0] RES_OK   = 2'd0;
  localparam logic [RES_W-1:0] RES_FULL = 2'd1;
  localparam logic [RES_W-1:0] RES_HELD = 2'd2;
  localparam logic [RES_W-1:0] RES_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] st;
    logic       hold;
  } slot_ent_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_ent_t         wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [RES_W-1:0]  status;
    logic [SLOT_W-1:0] running_task;
    logic              switched;
    logic [SLOT_W-1:0] new_slot;
    logic              join_done;
  } res_t;

  // Contents of a slot that was never written since reset
  function automatic slot_ent_t reset_ent(input logic [SLOT_W-1:0] a);
    slot_ent_t e;
    e.st   = (a == '0) ? ST_RUNNING : ST_FREE;
    e.hold = 1'b0;
    return e;
  endfunction

  // Next slot in ring order
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
    logic [SLOT_W-1:0] r;
    r = (a == SLOT_W'(MAX_TASKS - 1)) ? '0 : a + SLOT_W'(1);
    return r;
  endfunction

endpackage

// File: sv/round_robin_task_scheduler_unit.sv
// Channel   Handshake            Payload
// -------   ------------------   ------------------------------------------------
// in        in_valid / in_stall  op, target_slot
// out       out_valid/out_stall  status, running_task, switched, new_slot, join_done
//
// One request at a time: no new request is taken before the last result is
// registered. A preempt change, an undefined op, a held tick, an early no-ready
// tick or yield and a join that frees its target or ends early need no scan. A ring
// scan of the table reads one slot per cycle, for up to MAX_TASKS slots.
// Reset is synchronous; the table returns to its reset contents at once.
// A result waits in the output register; out_stall only holds the final step.
module round_robin_task_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrts_pkg::OP_W-1:0]     op,
  input  logic [rrts_pkg::SLOT_W-1:0]   target_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrts_pkg::RES_W-1:0]    status,
  output logic [rrts_pkg::SLOT_W-1:0]   running_task,
  output logic                          switched,
  output logic [rrts_pkg::SLOT_W-1:0]   new_slot,
  output logic                          join_done
);

`include "round_robin_task_scheduler_unit_macros.svh"

  rrts_pkg::mem_req_t  mem_req;
  rrts_pkg::slot_ent_t rd_data;
  rrts_pkg::res_t      res;
  logic                done;
  logic                res_free;

  assign res_free = !out_valid || !out_stall;

  rrts_slot_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  rrts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .target_slot (target_slot),
    .res_free    (res_free),
    .done        (done),
    .res         (res),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status       <= res.status;
      running_task <= res.running_task;
      switched     <= res.switched;
      new_slot     <= res.new_slot;
      join_done    <= res.join_done;
    end
  end

  // Checks
  `RRTS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept did not block")
  `RRTS_ASSERT_IMPL(a_done_needs_room, done, res_free, "result overwrote a pending result")
  `RRTS_ASSERT_IMPL(a_switch_is_ok, out_valid && switched, status == rrts_pkg::RES_OK, "switch with bad status")
  `RRTS_ASSERT_IMPL(a_join_no_switch, out_valid && join_done, !switched && status == rrts_pkg::RES_OK, "join freed with switch")

endmodule

// File: sv/rrts_slot_mem.sv
// Task table: one write port, one registered read port (old data on collision).
// Per-slot valid bits stand in for the reset contents.
module rrts_slot_mem (
  input  logic                clk,
  input  logic                rst,
  input  rrts_pkg::mem_req_t  req,
  output rrts_pkg::slot_ent_t rd_data
);

  rrts_pkg::slot_ent_t                  mem [rrts_pkg::MAX_TASKS];
  logic [rrts_pkg::MAX_TASKS-1:0]       written;
  rrts_pkg::slot_ent_t                  rd_q;
  logic                                 rd_written;
  logic [rrts_pkg::SLOT_W-1:0]          raddr_q;

  // Storage array
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q    <= mem[req.raddr];
    raddr_q <= req.raddr;
  end

  // Written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      rd_written <= written[req.raddr];
      if (req.we) begin
        written[req.waddr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_written ? rd_q : rrts_pkg::reset_ent(raddr_q);

endmodule

// File: sv/rrts_ctrl.sv
// Event sequencer: reads the current slot, scans the table one slot per cycle
// when a fork or a reschedule needs it, and writes back the changed entries.
module rrts_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrts_pkg::OP_W-1:0]     op,
  input  logic [rrts_pkg::SLOT_W-1:0]   target_slot,
  input  logic                          res_free,
  output logic                          done,
  output rrts_pkg::res_t                res,
  output rrts_pkg::mem_req_t            mem_req,
  input  rrts_pkg::slot_ent_t           rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDCUR = 3'd1;
  localparam logic [2:0] S_JTGT  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_WR1   = 3'd4;
  localparam logic [2:0] S_WR2   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam int SW = rrts_pkg::SLOT_W;

  logic [2:0]                    state, state_next;
  logic [rrts_pkg::OP_W-1:0]     op_q, op_q_next;
  logic [SW-1:0]                 tgt_q, tgt_q_next;
  logic [SW-1:0]                 cur, cur_next;
  logic [SW-1:0]                 cur_before, cur_before_next;
  logic [rrts_pkg::CNT_W-1:0]    live, live_next;
  rrts_pkg::slot_ent_t           cur_ent, cur_ent_next;
  logic                          want_free, want_free_next;
  logic [SW-1:0]                 iss_addr, iss_addr_next;
  logic [rrts_pkg::CNT_W-1:0]    iss_cnt, iss_cnt_next;
  logic                          pend, pend_next;
  logic [SW-1:0]                 pend_addr, pend_addr_next;
  logic [SW-1:0]                 hit_addr, hit_addr_next;
  logic                          do_wr2, do_wr2_next;
  rrts_pkg::slot_ent_t           wr1_data, wr1_data_next;
  rrts_pkg::slot_ent_t           wr2_data, wr2_data_next;
  logic [rrts_pkg::RES_W-1:0]    res_status, res_status_next;
  logic [SW-1:0]                 res_new, res_new_next;
  logic                          res_join, res_join_next;

  logic                          sched_req;
  logic                          sched_forced;
  logic [1:0]                    sched_st;
  logic                          hit;
  logic                          tgt_in_range;

  assign in_stall     = (state != S_IDLE);
  assign tgt_in_range = ({1'b0, tgt_q} < (SW + 1)'(rrts_pkg::MAX_TASKS));
  assign hit = pend && (want_free ? (rd_data.st == rrts_pkg::ST_FREE)
                                  : (rd_data.st == rrts_pkg::ST_READY));

  // Result fields
  always_comb begin
    res.status       = res_status;
    res.running_task = cur;
    res.switched     = (cur != cur_before);
    res.new_slot     = res_new;
    res.join_done    = res_join;
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    op_q_next       = op_q;
    tgt_q_next      = tgt_q;
    cur_next        = cur;
    cur_before_next = cur_before;
    live_next       = live;
    cur_ent_next    = cur_ent;
    want_free_next  = want_free;
    iss_addr_next   = iss_addr;
    iss_cnt_next    = iss_cnt;
    pend_next       = 1'b0;
    pend_addr_next  = pend_addr;
    hit_addr_next   = hit_addr;
    do_wr2_next     = do_wr2;
    wr1_data_next   = wr1_data;
    wr2_data_next   = wr2_data;
    res_status_next = res_status;
    res_new_next    = res_new;
    res_join_next   = res_join;
    sched_req       = 1'b0;
    sched_forced    = 1'b0;
    sched_st        = cur_ent.st;
    done            = 1'b0;
    mem_req.we      = 1'b0;
    mem_req.waddr   = cur;
    mem_req.wdata   = rd_data;
    mem_req.raddr   = cur;

    unique case (state)
      S_IDLE: begin
        // current slot is read every idle cycle
        if (in_valid) begin
          op_q_next       = op;
          tgt_q_next      = target_slot;
          cur_before_next = cur;
          res_status_next = rrts_pkg::RES_OK;
          res_new_next    = '0;
          res_join_next   = 1'b0;
          state_next      = S_RDCUR;
        end
      end

      S_RDCUR: begin
        cur_ent_next = rd_data;
        sched_st     = rd_data.st;
        case (op_q) inside
          rrts_pkg::OP_FORK: begin
            want_free_next = 1'b1;
            iss_addr_next  = '0;
            iss_cnt_next   = '0;
            state_next     = S_SCAN;
          end
          rrts_pkg::OP_TICK: begin
            if (rd_data.hold) begin
              res_status_next = rrts_pkg::RES_HELD;
              state_next      = S_FIN;
            end else begin
              sched_req = 1'b1;
            end
          end
          rrts_pkg::OP_YIELD: sched_req = 1'b1;
          rrts_pkg::OP_EXIT: begin
            if ((rd_data.st == rrts_pkg::ST_READY || rd_data.st == rrts_pkg::ST_RUNNING)
                && live != '0) begin
              live_next = live - rrts_pkg::CNT_W'(1);
            end
            cur_ent_next.st   = rrts_pkg::ST_ZOMBIE;
            mem_req.we        = 1'b1;
            mem_req.wdata.st  = rrts_pkg::ST_ZOMBIE;
            sched_req         = 1'b1;
            sched_forced      = 1'b1;
          end
          rrts_pkg::OP_JOIN: begin
            if (tgt_in_range) begin
              mem_req.raddr = tgt_q;
              state_next    = S_JTGT;
            end else begin
              sched_req = 1'b1;
            end
          end
          rrts_pkg::OP_PEN, rrts_pkg::OP_PDIS: begin
            mem_req.we         = 1'b1;
            mem_req.wdata.hold = (op_q == rrts_pkg::OP_PDIS);
            state_next         = S_FIN;
          end
          default: state_next = S_FIN;
        endcase
      end

      S_JTGT: begin
        if (rd_data.st == rrts_pkg::ST_ZOMBIE) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = tgt_q;
          mem_req.wdata = '{st: rrts_pkg::ST_FREE, hold: 1'b0};
          res_join_next = 1'b1;
          state_next    = S_FIN;
        end else begin
          sched_req = 1'b1;
        end
      end

      S_SCAN: begin
        if (hit) begin
          // found a slot: queue the write-backs
          hit_addr_next   = pend_addr;
          do_wr2_next     = 1'b1;
          res_status_next = rrts_pkg::RES_OK;
          state_next      = S_WR1;
          if (want_free) begin
            wr1_data_next = '{st: cur_ent.st, hold: 1'b0};
            wr2_data_next = '{st: rrts_pkg::ST_READY, hold: (pend_addr != cur)};
            live_next     = live + rrts_pkg::CNT_W'(1);
            res_new_next  = pend_addr;
          end else begin
            wr1_data_next = '{st: (cur_ent.st == rrts_pkg::ST_ZOMBIE) ?
                                  rrts_pkg::ST_ZOMBIE : rrts_pkg::ST_READY,
                              hold: cur_ent.hold};
            wr2_data_next = '{st: rrts_pkg::ST_RUNNING, hold: 1'b0};
          end
        end else if (iss_cnt == rrts_pkg::CNT_W'(rrts_pkg::MAX_TASKS)) begin
          // every slot checked without a match
          if (want_free) begin
            res_status_next = rrts_pkg::RES_FULL;
            state_next      = S_FIN;
          end else begin
            wr1_data_next   = '{st: cur_ent.st, hold: 1'b0};
            do_wr2_next     = 1'b0;
            res_status_next = rrts_pkg::RES_NONE;
            state_next      = S_WR1;
          end
        end else begin
          // issue the next slot read
          mem_req.raddr  = iss_addr;
          pend_next      = 1'b1;
          pend_addr_next = iss_addr;
          iss_addr_next  = rrts_pkg::slot_inc(iss_addr);
          iss_cnt_next   = iss_cnt + rrts_pkg::CNT_W'(1);
        end
      end

      S_WR1: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = wr1_data;
        state_next    = do_wr2 ? S_WR2 : S_FIN;
      end

      S_WR2: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = hit_addr;
        mem_req.wdata = wr2_data;
        if (!want_free) begin
          cur_next = hit_addr;
        end
        state_next = S_FIN;
      end

      S_FIN: begin
        if (res_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Scheduling entry: either bail out early or start the ring scan
    if (sched_req) begin
      if (!sched_forced && live <= rrts_pkg::CNT_W'(1) && sched_st != rrts_pkg::ST_ZOMBIE) begin
        res_status_next = rrts_pkg::RES_NONE;
        state_next      = S_FIN;
      end else begin
        want_free_next = 1'b0;
        iss_addr_next  = rrts_pkg::slot_inc(cur);
        iss_cnt_next   = '0;
        state_next     = S_SCAN;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      live  <= rrts_pkg::CNT_W'(1);
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      live  <= live_next;
      pend  <= pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_q       <= op_q_next;
    tgt_q      <= tgt_q_next;
    cur_before <= cur_before_next;
    cur_ent    <= cur_ent_next;
    want_free  <= want_free_next;
    iss_addr   <= iss_addr_next;
    iss_cnt    <= iss_cnt_next;
    pend_addr  <= pend_addr_next;
    hit_addr   <= hit_addr_next;
    do_wr2     <= do_wr2_next;
    wr1_data   <= wr1_data_next;
    wr2_data   <= wr2_data_next;
    res_status <= res_status_next;
    res_new    <= res_new_next;
    res_join   <= res_join_next;
  end

endmodule

// File: verif/round_robin_task_scheduler_unit_test.sv
module round_robin_task_scheduler_unit_test;
  import rrts_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF = 3'd7;
  localparam int RANDOM_REQS = 1880;
  localparam int PHASE_LEN   = 40;
  localparam int TAIL_REQS   = 150;
  localparam int HOLD_OFF    = 80;
  localparam int HOLD_OFF_AT = 250;
  localparam int DRAIN_WAIT  = 20;
  localparam int IDLE_LIMIT  = 1000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] tgt;
  } sched_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op = OP_FORK;
  logic [SLOT_W-1:0]   target_slot = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RES_W-1:0]    status;
  logic [SLOT_W-1:0]   running_task;
  logic                switched;
  logic [SLOT_W-1:0]   new_slot;
  logic                join_done;

  // Shadow of the task table
  logic [1:0]          slot_st [MAX_TASKS];
  bit                  slot_hold [MAX_TASKS];
  logic [SLOT_W-1:0]   cur_slot;
  int                  live_tasks;

  sched_req_t          pending_requests[$];
  res_t                expected_results[$];
  res_t                want;
  sched_req_t          next_req;
  int                  failures = 0;
  int                  results_checked = 0;
  int                  send_gap = 0;
  int                  stall_left = 0;
  bit                  hold_off_done = 0;
  int                  idle_cycles = 0;

  // Op mixes: fork, tick, yield, exit, join, preempt en, preempt dis, undefined
  logic [OP_W-1:0] op_list [8] = '{OP_FORK, OP_TICK, OP_YIELD, OP_EXIT,
                                   OP_JOIN, OP_PEN, OP_PDIS, OP_UNDEF};
  int op_weight [3][8] = '{'{28, 6, 10, 20, 28, 3, 4, 1},
                           '{6, 34, 20, 5, 5, 14, 15, 1},
                           '{15, 15, 15, 14, 15, 12, 12, 2}};

  round_robin_task_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .target_slot  (target_slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .running_task (running_task),
    .switched     (switched),
    .new_slot     (new_slot),
    .join_done    (join_done)
  );

  always #5 clk = ~clk;

  // Ring-order search for the next ready task after the current slot
  function automatic logic [RES_W-1:0] reschedule(input bit forced);
    int s;
    bit cur_zombie;
    cur_zombie = (slot_st[cur_slot] == ST_ZOMBIE);
    if (!forced && live_tasks <= 1 && !cur_zombie) return RES_NONE;
    for (int i = 1; i <= MAX_TASKS; i++) begin
      s = (int'(cur_slot) + i) % MAX_TASKS;
      if (slot_st[s] == ST_READY) begin
        if (!cur_zombie) slot_st[cur_slot] = ST_READY;
        slot_st[s] = ST_RUNNING;
        slot_hold[s] = 1'b0;
        cur_slot = SLOT_W'(s);
        return RES_OK;
      end
    end
    slot_hold[cur_slot] = 1'b0;
    return RES_NONE;
  endfunction

  // Update the shadow table for one request and queue its result
  function automatic void apply_request(input sched_req_t req);
    res_t r;
    logic [SLOT_W-1:0] prev;
    r = '0;
    prev = cur_slot;
    case (req.op)
      OP_FORK: begin
        r.status = RES_FULL;
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (slot_st[i] == ST_FREE) begin
            slot_st[i] = ST_READY;
            slot_hold[i] = 1'b1;
            slot_hold[cur_slot] = 1'b0;
            live_tasks++;
            r.new_slot = SLOT_W'(i);
            r.status = RES_OK;
            break;
          end
        end
      end
      OP_TICK: begin
        if (slot_hold[cur_slot]) r.status = RES_HELD;
        else r.status = reschedule(1'b0);
      end
      OP_YIELD: r.status = reschedule(1'b0);
      OP_EXIT: begin
        if ((slot_st[cur_slot] == ST_READY || slot_st[cur_slot] == ST_RUNNING) &&
            live_tasks > 0)
          live_tasks--;
        slot_st[cur_slot] = ST_ZOMBIE;
        r.status = reschedule(1'b1);
      end
      OP_JOIN: begin
        if (slot_st[req.tgt] == ST_ZOMBIE) begin
          slot_st[req.tgt] = ST_FREE;
          slot_hold[req.tgt] = 1'b0;
          r.join_done = 1'b1;
          r.status = RES_OK;
        end else begin
          r.status = reschedule(1'b0);
        end
      end
      OP_PEN: slot_hold[cur_slot] = 1'b0;
      OP_PDIS: slot_hold[cur_slot] = 1'b1;
      default: ;
    endcase
    r.running_task = cur_slot;
    r.switched = (cur_slot != prev);
    expected_results.push_back(r);
  endfunction

  task automatic queue_req(input logic [OP_W-1:0] o, input logic [SLOT_W-1:0] t);
    sched_req_t req;
    req.op = o;
    req.tgt = t;
    pending_requests.push_back(req);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_req.op = op;
        next_req.tgt = target_slot;
        apply_request(next_req);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          op <= next_req.op;
          target_slot <= next_req.tgt;
          if (pending_requests.size() > TAIL_REQS && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d running_task %0d", status, running_task);
          failures++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
          end
          if (running_task !== want.running_task) begin
            $error("running_task: expected %0d, got %0d", want.running_task, running_task);
            failures++;
          end
          if (switched !== want.switched) begin
            $error("switched: expected %0d, got %0d", want.switched, switched);
            failures++;
          end
          if (new_slot !== want.new_slot) begin
            $error("new_slot: expected %0d, got %0d", want.new_slot, new_slot);
            failures++;
          end
          if (join_done !== want.join_done) begin
            $error("join_done: expected %0d, got %0d", want.join_done, join_done);
            failures++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_off_done && results_checked >= HOLD_OFF_AT) begin
        hold_off_done = 1;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (pending_requests.size() > TAIL_REQS && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 5);
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("round_robin_task_scheduler_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int mix;
    int r;
    int k;

    // shadow table reset: slot 0 running, rest free
    for (int i = 0; i < MAX_TASKS; i++) begin
      slot_st[i] = ST_FREE;
      slot_hold[i] = 1'b0;
    end
    slot_st[0] = ST_RUNNING;
    cur_slot = '0;
    live_tasks = 1;

    // directed: lone task, preemption hold, full table, exit and join
    queue_req(OP_YIELD, 3'd0);
    queue_req(OP_TICK, 3'd0);
    queue_req(OP_PDIS, 3'd0);
    queue_req(OP_TICK, 3'd0);
    queue_req(OP_PEN, 3'd0);
    repeat (MAX_TASKS) queue_req(OP_FORK, 3'd7);
    queue_req(OP_TICK, 3'd0);
    queue_req(OP_YIELD, 3'd0);
    queue_req(OP_PDIS, 3'd0);
    queue_req(OP_TICK, 3'd0);
    queue_req(OP_EXIT, 3'd0);
    queue_req(OP_JOIN, 3'd2);
    queue_req(OP_JOIN, 3'd7);
    queue_req(OP_UNDEF, 3'd5);
    queue_req(OP_PEN, 3'd0);
    queue_req(OP_EXIT, 3'd0);
    queue_req(OP_EXIT, 3'd0);

    // random phases, each with its own op mix
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % PHASE_LEN == 0) mix = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      k = 0;
      while (k < 7 && r >= op_weight[mix][k]) begin
        r -= op_weight[mix][k];
        k++;
      end
      queue_req(op_list[k], SLOT_W'($urandom_range(0, MAX_TASKS - 1)));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("round_robin_task_scheduler_unit: match");
    end else begin
      $display("round_robin_task_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/rrts_pkg.sv
sv/rrts_slot_mem.sv
sv/rrts_ctrl.sv
sv/round_robin_task_scheduler_unit.sv
verif/round_robin_task_scheduler_unit_test.sv
